[hw/rtl/csvfd_pkg.sv]
// Shared types and constants for the CSV field decoder.
// Used by csvfd_step and csv_field_decoder; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package csvfd_pkg;

	// Characters that steer the parser.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// Parse mode codes.
	localparam logic [2:0] MODE_START      = 3'd0;
	localparam logic [2:0] MODE_AFTER_CR   = 3'd1;
	localparam logic [2:0] MODE_UNQUOTED   = 3'd2;
	localparam logic [2:0] MODE_QUOTED     = 3'd3;
	localparam logic [2:0] MODE_QUOTE_SEEN = 3'd4;
	localparam logic [2:0] MODE_ERROR      = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Field delimiters.
	localparam logic [1:0] DELIM_COMMA = 2'd0;
	localparam logic [1:0] DELIM_CR    = 2'd1;
	localparam logic [1:0] DELIM_LF    = 2'd2;
	localparam logic [1:0] DELIM_EOT   = 2'd3;

	// One possible result of a single byte step.
	typedef struct packed {
		logic       present;
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] delim;
	} csvfd_res_t;

endpackage

`default_nettype wire

[hw/rtl/csvfd_step.sv]
// Combinational per-byte step of the CSV parse mode machine.
// Depends on csvfd_pkg for mode, kind and delimiter codes.
`timescale 1ns / 1ps
`default_nettype none

module csvfd_step (
	input  wire logic [2:0]             mode,
	input  wire logic [7:0]             text_byte,
	input  wire logic                   end_of_text,
	output logic [2:0]                  next_mode,
	output csvfd_pkg::csvfd_res_t       res
);
	import csvfd_pkg::*;

	logic is_delim;
	logic [1:0] delim_code;
	logic [2:0] delim_mode;
	logic field_start;

	// Classify the byte as a field delimiter and pick the mode that follows it.
	always_comb begin
		is_delim = 1'b1;
		delim_code = DELIM_COMMA;
		delim_mode = MODE_START;
		case (text_byte)
			CH_COMMA: begin
				delim_code = DELIM_COMMA;
			end
			CH_CR: begin
				delim_code = DELIM_CR;
				delim_mode = MODE_AFTER_CR;
			end
			CH_LF: begin
				delim_code = DELIM_LF;
			end
			default: begin
				is_delim = 1'b0;
			end
		endcase
	end

	// After a CR delimiter, any byte but LF is handled as at field start.
	assign field_start = (mode == MODE_START) ||
		((mode == MODE_AFTER_CR) && (text_byte != CH_LF));

	// Mode transition and result selection.
	always_comb begin
		next_mode = mode;
		res = '0;
		if (end_of_text) begin
			next_mode = MODE_START;
			if (mode == MODE_QUOTED) begin
				res.present = 1'b1;
				res.kind = KIND_ERROR;
			end else if (mode != MODE_ERROR) begin
				res.present = 1'b1;
				res.kind = KIND_END;
				res.delim = DELIM_EOT;
			end
		end else if (field_start) begin
			if (text_byte == CH_QUOTE) begin
				next_mode = MODE_QUOTED;
			end else if (is_delim) begin
				next_mode = delim_mode;
				res.present = 1'b1;
				res.kind = KIND_END;
				res.delim = delim_code;
			end else begin
				next_mode = MODE_UNQUOTED;
				res.present = 1'b1;
				res.kind = KIND_DATA;
				res.data = text_byte;
			end
		end else begin
			case (mode)
				MODE_AFTER_CR: begin
					// Only reached on LF, which is swallowed.
					next_mode = MODE_START;
				end
				MODE_UNQUOTED: begin
					res.present = 1'b1;
					if (is_delim) begin
						next_mode = delim_mode;
						res.kind = KIND_END;
						res.delim = delim_code;
					end else begin
						res.kind = KIND_DATA;
						res.data = text_byte;
					end
				end
				MODE_QUOTED: begin
					if (text_byte == CH_QUOTE) begin
						next_mode = MODE_QUOTE_SEEN;
					end else begin
						res.present = 1'b1;
						res.kind = KIND_DATA;
						res.data = text_byte;
					end
				end
				MODE_QUOTE_SEEN: begin
					res.present = 1'b1;
					if (text_byte == CH_QUOTE) begin
						next_mode = MODE_QUOTED;
						res.kind = KIND_DATA;
						res.data = CH_QUOTE;
					end else if (is_delim) begin
						next_mode = delim_mode;
						res.kind = KIND_END;
						res.delim = delim_code;
					end else begin
						next_mode = MODE_ERROR;
						res.kind = KIND_ERROR;
					end
				end
				MODE_ERROR: begin
					next_mode = MODE_ERROR;
				end
				default: begin
					next_mode = MODE_START;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/csv_field_decoder.sv]
// Channel   Direction  Handshake           Beat contents
// in        input      in_valid/in_ready   text_byte, end_of_text
// out       output     out_valid/out_ready kind, data_byte, delimiter
//
// Each input beat is held in an input register, passes the mode machine and
// lands in a result register. One beat per cycle is sustained while the
// output is not stalled; the single mode register sets that rate.
// Reset clears both stages and returns the parser to field start.
// A stalled result holds only beats that produce a result; a beat that
// yields nothing passes the input register even while the output waits.
// Top level of the CSV field decoder; depends on csvfd_pkg and csvfd_step.
`timescale 1ns / 1ps
`default_nettype none

module csv_field_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte,
	output logic [1:0]      delimiter
);
	import csvfd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;
	logic [2:0] mode_q;
	logic [2:0] next_mode;
	csvfd_res_t res;
	logic       valid_s2;
	logic [1:0] kind_s2;
	logic [7:0] data_s2;
	logic [1:0] delim_s2;
	logic       advance;

	// The held beat moves on when it has no result or the result slot frees.
	assign advance  = valid_s1 && (!res.present || !valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			eot_s1 <= end_of_text;
		end
	end

	csvfd_step u_step (
		.mode       (mode_q),
		.text_byte  (byte_s1),
		.end_of_text(eot_s1),
		.next_mode  (next_mode),
		.res        (res)
	);

	// Parse mode register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_START;
		end else if (advance) begin
			mode_q <= next_mode;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res.present) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.present) begin
			kind_s2 <= res.kind;
			data_s2 <= res.data;
			delim_s2 <= res.delim;
		end
	end

	assign out_valid = valid_s2;
	assign kind      = kind_s2;
	assign data_byte = data_s2;
	assign delimiter = delim_s2;

	// Checks on the mode machine and the result encoding.
	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_ERROR)
		else $error("parse mode left the defined codes");

	a_eot_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eot_s1) |=> (mode_q == MODE_START))
		else $error("end of text did not return to field start");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (kind_s2 == KIND_DATA || kind_s2 == KIND_END ||
			kind_s2 == KIND_ERROR))
		else $error("result kind out of range");

	a_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 != KIND_DATA) |-> (data_s2 == 8'd0))
		else $error("data byte not zero on non-data result");

	a_delim_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 != KIND_END) |-> (delim_s2 == DELIM_COMMA))
		else $error("delimiter not zero on non-end result");

endmodule

`default_nettype wire

[dv/tb_csv_field_decoder.sv]
// Self-checking testbench for csv_field_decoder: directed CSV text, then random records.
// It predicts each result beat from its own model of the parser.
// Depends on csvfd_pkg and the csv_field_decoder RTL.
`timescale 1ns / 1ps

module tb_csv_field_decoder;
	import csvfd_pkg::*;

	localparam int STALL_LIMIT = 1000;

	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic [7:0] text_byte   = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [1:0] delimiter;

	// Percent of cycles in which each side idles.
	int tx_idle_pct = 28;
	int rx_idle_pct = 66;

	int beats_sent  = 0;
	int err_count   = 0;
	int idle_cycles = 0;

	// Parser mode of the prediction and the tokens still due from the block.
	logic [2:0] csv_mode = MODE_START;
	csvfd_res_t pending_tokens[$];

	csv_field_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.data_byte  (data_byte),
		.delimiter  (delimiter)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic csvfd_res_t make_token(input logic [1:0] k, input logic [7:0] d,
		input logic [1:0] dl);
		csvfd_res_t t;
		t.present = 1'b1;
		t.kind    = k;
		t.data    = d;
		t.delim   = dl;
		return t;
	endfunction

	// A comma, CR or LF closes the field; any other byte leaves the token empty.
	function automatic csvfd_res_t close_on_delimiter(input logic [7:0] b);
		csvfd_res_t t;
		t = '0;
		if (b == CH_COMMA) begin
			csv_mode = MODE_START;
			t = make_token(KIND_END, 8'h00, DELIM_COMMA);
		end else if (b == CH_CR) begin
			csv_mode = MODE_AFTER_CR;
			t = make_token(KIND_END, 8'h00, DELIM_CR);
		end else if (b == CH_LF) begin
			csv_mode = MODE_START;
			t = make_token(KIND_END, 8'h00, DELIM_LF);
		end
		return t;
	endfunction

	// Advances the predicted parser by one beat and returns the token it yields.
	function automatic csvfd_res_t decode_csv_byte(input logic [7:0] b, input logic eot);
		csvfd_res_t t;
		logic [2:0] m;
		t = '0;
		m = csv_mode;
		if (eot) begin
			csv_mode = MODE_START;
			if (m == MODE_QUOTED)
				t = make_token(KIND_ERROR, 8'h00, DELIM_COMMA);
			else if (m != MODE_ERROR)
				t = make_token(KIND_END, 8'h00, DELIM_EOT);
			return t;
		end
		case (m)
			MODE_START, MODE_AFTER_CR: begin
				if (m == MODE_AFTER_CR && b == CH_LF) begin
					csv_mode = MODE_START;
				end else if (b == CH_QUOTE) begin
					csv_mode = MODE_QUOTED;
				end else begin
					t = close_on_delimiter(b);
					if (!t.present) begin
						csv_mode = MODE_UNQUOTED;
						t = make_token(KIND_DATA, b, DELIM_COMMA);
					end
				end
			end
			MODE_UNQUOTED: begin
				t = close_on_delimiter(b);
				if (!t.present)
					t = make_token(KIND_DATA, b, DELIM_COMMA);
			end
			MODE_QUOTED: begin
				if (b == CH_QUOTE)
					csv_mode = MODE_QUOTE_SEEN;
				else
					t = make_token(KIND_DATA, b, DELIM_COMMA);
			end
			MODE_QUOTE_SEEN: begin
				if (b == CH_QUOTE) begin
					csv_mode = MODE_QUOTED;
					t = make_token(KIND_DATA, CH_QUOTE, DELIM_COMMA);
				end else begin
					t = close_on_delimiter(b);
					if (!t.present) begin
						csv_mode = MODE_ERROR;
						t = make_token(KIND_ERROR, 8'h00, DELIM_COMMA);
					end
				end
			end
			MODE_ERROR: begin
			end
			default: csv_mode = MODE_START;
		endcase
		return t;
	endfunction

	// Predict on every accepted input beat and check every accepted result beat.
	always @(posedge clk) begin
		csvfd_res_t exp_tok;
		csvfd_res_t new_tok;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_tokens.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result kind %0d data %0h delimiter %0d",
						$time, kind, data_byte, delimiter);
				end else begin
					exp_tok = pending_tokens.pop_front();
					if (kind !== exp_tok.kind || data_byte !== exp_tok.data
						|| delimiter !== exp_tok.delim) begin
						err_count++;
						$display("%0t: expected kind %0d data %0h delimiter %0d, actual %0d %0h %0d",
							$time, exp_tok.kind, exp_tok.data, exp_tok.delim,
							kind, data_byte, delimiter);
					end
				end
			end
			if (in_valid && in_ready) begin
				new_tok = decode_csv_byte(text_byte, end_of_text);
				if (new_tok.present)
					pending_tokens.push_back(new_tok);
			end
		end
	end

	// Receiver stalls at random.
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

	// Watchdog on cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_csv_field_decoder: errors");
				$finish;
			end
		end
	end

	// Sends one input beat, with a random gap first, and returns once it is taken.
	// Each gap cycle is drawn on its own, so the sender idles in the given share of cycles.
	task automatic send_text_beat(input logic [7:0] b, input logic eot);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic send_char(input logic [7:0] b);
		send_text_beat(b, 1'b0);
	endtask

	// Text byte that favors the characters that steer the parser.
	function automatic logic [7:0] pick_text_char();
		logic [7:0] steer [4];
		steer = '{CH_QUOTE, CH_COMMA, CH_CR, CH_LF};
		if ($urandom_range(0, 3) == 0)
			return steer[$urandom_range(0, 3)];
		return 8'($urandom_range(0, 255));
	endfunction

	// End marker at field start, then an unquoted field with a quote and extreme bytes.
	task automatic test_plain_fields();
		send_text_beat(8'hFF, 1'b1);
		send_char("a");
		send_char(CH_QUOTE);
		send_char(8'hFF);
		send_char(8'h00);
		send_char(CH_COMMA);
	endtask

	// Quoted field holding a comma, CR, LF and a doubled quote, closed by a CR
	// whose following LF must be swallowed.
	task automatic test_quoted_fields();
		send_char(CH_QUOTE);
		send_char(CH_COMMA);
		send_char(CH_CR);
		send_char(CH_LF);
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_char(CH_CR);
		send_char(CH_LF);
	endtask

	// Stray byte after a closing quote, end inside quotes, end after a closing quote.
	task automatic test_malformed_fields();
		send_char(CH_QUOTE);
		send_char("x");
		send_char(CH_QUOTE);
		send_char("z");
		send_char("q");
		send_text_beat(8'h00, 1'b1);
		send_char(CH_QUOTE);
		send_char("a");
		send_text_beat(8'h55, 1'b1);
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_text_beat(8'hAA, 1'b1);
	endtask

	// One random record: mostly well-formed fields, some broken ones and noise.
	task automatic send_random_record();
		int nf;
		int len;
		int sel;
		logic [7:0] c;
		nf = $urandom_range(1, 4);
		for (int f = 0; f < nf; f++) begin
			sel = $urandom_range(0, 9);
			if (sel < 5) begin
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					do c = 8'($urandom_range(0, 255));
					while (c == CH_COMMA || c == CH_CR || c == CH_LF
						|| (i == 0 && c == CH_QUOTE));
					send_char(c);
				end
			end else if (sel < 8) begin
				send_char(CH_QUOTE);
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					c = pick_text_char();
					send_char(c);
					if (c == CH_QUOTE)
						send_char(c);
				end
				send_char(CH_QUOTE);
			end else if (sel == 8) begin
				send_char(CH_QUOTE);
				send_char(pick_text_char());
				send_char(CH_QUOTE);
				do c = 8'($urandom_range(0, 255));
				while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
				send_char(c);
				len = $urandom_range(0, 3);
				for (int i = 0; i < len; i++)
					send_char(pick_text_char());
			end else begin
				len = $urandom_range(1, 4);
				for (int i = 0; i < len; i++)
					send_char(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 19) == 0)
				send_text_beat(8'($urandom_range(0, 255)), 1'b1);
			if (f < nf - 1)
				send_char(CH_COMMA);
		end
		sel = $urandom_range(0, 7);
		if (sel < 3) begin
			send_char(CH_LF);
		end else if (sel == 3) begin
			send_char(CH_CR);
		end else if (sel < 6) begin
			send_char(CH_CR);
			send_char(CH_LF);
		end else begin
			if (sel == 7)
				send_char(CH_CR);
			send_text_beat(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	task automatic test_random_text(input int n_beats);
		int stop_at;
		stop_at = beats_sent + n_beats;
		while (beats_sent < stop_at)
			send_random_record();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_fields();
		test_quoted_fields();
		test_malformed_fields();

		tx_idle_pct = 28;
		rx_idle_pct = 66;
		test_random_text(133);
		tx_idle_pct = 66;
		rx_idle_pct = 28;
		test_random_text(133);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_text(134);

		// Drain every outstanding result, then give the pipeline time to misbehave.
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (err_count == 0)
			$display("tb_csv_field_decoder: clean");
		else
			$display("tb_csv_field_decoder: errors");
		$finish;
	end

endmodule
